// ===== rtl/aijc_pkg.sv =====
// ----------------------------------------------------------------------------
// aijc_pkg
// Shared types, constants and helpers of the joint controller.
// ----------------------------------------------------------------------------
package aijc_pkg;

    localparam int NUM_JOINTS = 7;
    localparam int JW         = 3;    // joint index width
    localparam int DW         = 32;   // Q12.20 data width
    localparam int PW         = 31;   // precision and gain width
    localparam int HW         = 32;   // step size width
    localparam int AW         = 40;   // accumulator width
    localparam int CIW        = 3;    // config index width
    localparam int EW         = 34;   // prediction error width
    localparam int XW         = 64;   // multiplier wide operand width
    localparam int YW         = 33;   // multiplier narrow operand width
    localparam int PRW        = XW + YW;

    localparam logic [59:0]   SAT_MID = '1;
    localparam logic [AW-1:0] MAX40   = '1;

    // reset values of the registers
    localparam logic [PW-1:0] RST_PY = PW'(1048576);
    localparam logic [PW-1:0] RST_PV = PW'(1048576);
    localparam logic [PW-1:0] RST_PM = PW'(209715);
    localparam logic [PW-1:0] RST_PA = PW'(104858);
    localparam logic [PW-1:0] RST_K  = PW'(12236882);
    localparam logic [PW-1:0] RST_KA = PW'(734003200);
    localparam logic [HW-1:0] RST_H  = HW'(4294967);

    typedef enum logic [CIW-1:0] {
        REG_PY = 3'd0,
        REG_PV = 3'd1,
        REG_PM = 3'd2,
        REG_PA = 3'd3,
        REG_K  = 3'd4,
        REG_KA = 3'd5,
        REG_H  = 3'd6
    } reg_idx_t;

    // micro operations, one multiply each
    typedef enum logic [4:0] {
        U_SQY_A, U_SQY_B, U_SQV_A, U_SQV_B,
        U_SQM_A, U_SQM_B, U_SQA_A, U_SQA_B,
        U_WY, U_WV, U_WM, U_WA,
        U_D1, U_D2, U_D3,
        U_MU, U_MP, U_MA,
        U_GV, U_GY, U_GKA, U_TQ
    } uop_t;

    typedef enum logic [1:0] {
        M_RAW, M_W40, M_S20, M_S32
    } mmode_t;

    typedef struct packed {
        logic load;
        logic read;
        logic diff;
        logic setup;
        logic mlo;
        logic mhi;
        logic post;
        logic commit;
        uop_t uop;
    } cmd_t;

    typedef struct packed {
        logic joint_ok;
        logic out_free;
    } stat_t;

    function automatic logic signed [DW-1:0] sat32(input logic signed [63:0] v);
        logic signed [DW-1:0] r;
        if (v > 64'sd2147483647)
            r = 32'sh7fffffff;
        else if (v < -64'sd2147483648)
            r = 32'sh80000000;
        else
            r = v[DW-1:0];
        return r;
    endfunction

    function automatic logic [AW-1:0] add40(input logic [AW-1:0] a, input logic [AW-1:0] b);
        logic [AW:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[AW] ? MAX40 : s[AW-1:0];
    endfunction

endpackage

// ===== rtl/aijc_if.sv =====
// ----------------------------------------------------------------------------
// aijc_if
// Valid/ready channels of the joint controller: sample, result, config.
// ----------------------------------------------------------------------------
interface aijc_sample_if import aijc_pkg::*; ();
    logic                 valid;
    logic                 ready;
    logic [JW-1:0]        joint_index;
    logic signed [DW-1:0] measured_position;
    logic signed [DW-1:0] measured_velocity;
    logic signed [DW-1:0] goal_position;

    modport source (output valid, joint_index, measured_position, measured_velocity,
                    goal_position, input ready);
    modport sink   (input valid, joint_index, measured_position, measured_velocity,
                    goal_position, output ready);
endinterface

interface aijc_result_if import aijc_pkg::*; ();
    logic                 valid;
    logic                 ready;
    logic [JW-1:0]        joint_out;
    logic signed [DW-1:0] torque;
    logic signed [DW-1:0] belief_position;
    logic signed [DW-1:0] belief_velocity;
    logic signed [DW-1:0] belief_acceleration;
    logic                 step_done;
    logic [AW-1:0]        free_energy;
    logic [AW-1:0]        error_position_total;
    logic [AW-1:0]        error_velocity_total;

    modport source (output valid, joint_out, torque, belief_position, belief_velocity,
                    belief_acceleration, step_done, free_energy, error_position_total,
                    error_velocity_total, input ready);
    modport sink   (input valid, joint_out, torque, belief_position, belief_velocity,
                    belief_acceleration, step_done, free_energy, error_position_total,
                    error_velocity_total, output ready);
endinterface

interface aijc_cfg_if import aijc_pkg::*; ();
    logic           valid;
    logic           ready;
    logic [CIW-1:0] index;
    logic [31:0]    data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

// ===== rtl/aijc_ctrl.sv =====
// ----------------------------------------------------------------------------
// aijc_ctrl
// Sequencer: walks one joint sample through the shared multiplier.
// ----------------------------------------------------------------------------
module aijc_ctrl import aijc_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  sample_valid,
    output logic  sample_ready,
    input  stat_t stat,
    output cmd_t  cmd
);

    typedef enum logic [7:0] {
        ST_IDLE   = 8'b0000_0001,
        ST_READ   = 8'b0000_0010,
        ST_DIFF   = 8'b0000_0100,
        ST_SETUP  = 8'b0000_1000,
        ST_MLO    = 8'b0001_0000,
        ST_MHI    = 8'b0010_0000,
        ST_POST   = 8'b0100_0000,
        ST_COMMIT = 8'b1000_0000
    } ctl_state_t;

    ctl_state_t state_reg, state_next;
    uop_t       uop_reg, uop_next;

    // state and micro op registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            uop_reg   <= U_SQY_A;
        end
        else
        begin
            state_reg <= state_next;
            uop_reg   <= uop_next;
        end
    end

    assign sample_ready = (state_reg == ST_IDLE);

    // next state and commands
    always_comb
    begin
        state_next = state_reg;
        uop_next   = uop_reg;
        cmd        = '0;
        cmd.uop    = uop_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (sample_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = ST_READ;
                end
            end
            ST_READ:
            begin
                if (stat.joint_ok)
                begin
                    cmd.read   = 1'b1;
                    state_next = ST_DIFF;
                end
                else
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_DIFF:
            begin
                cmd.diff   = 1'b1;
                uop_next   = U_SQY_A;
                state_next = ST_SETUP;
            end
            ST_SETUP:
            begin
                cmd.setup  = 1'b1;
                state_next = ST_MLO;
            end
            ST_MLO:
            begin
                cmd.mlo    = 1'b1;
                state_next = ST_MHI;
            end
            ST_MHI:
            begin
                cmd.mhi    = 1'b1;
                state_next = ST_POST;
            end
            ST_POST:
            begin
                cmd.post = 1'b1;
                if (uop_reg == U_TQ)
                begin
                    state_next = ST_COMMIT;
                end
                else
                begin
                    uop_next   = uop_t'(uop_reg + 5'd1);
                    state_next = ST_SETUP;
                end
            end
            ST_COMMIT:
            begin
                if (stat.out_free)
                begin
                    cmd.commit = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

// ===== rtl/aijc_datapath.sv =====
// ----------------------------------------------------------------------------
// aijc_datapath
// Registers, joint stores, shared 64x33 multiplier and the result register.
// ----------------------------------------------------------------------------
module aijc_datapath import aijc_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  cmd_t                 cmd,
    output stat_t                stat,
    input  logic [JW-1:0]        joint_index,
    input  logic signed [DW-1:0] measured_position,
    input  logic signed [DW-1:0] measured_velocity,
    input  logic signed [DW-1:0] goal_position,
    input  logic                 cfg_write,
    input  logic [CIW-1:0]       cfg_index,
    input  logic [31:0]          cfg_data,
    input  logic                 result_ready,
    output logic                 result_valid,
    output logic [JW-1:0]        joint_out,
    output logic signed [DW-1:0] torque,
    output logic signed [DW-1:0] belief_position,
    output logic signed [DW-1:0] belief_velocity,
    output logic signed [DW-1:0] belief_acceleration,
    output logic                 step_done,
    output logic [AW-1:0]        free_energy,
    output logic [AW-1:0]        error_position_total,
    output logic [AW-1:0]        error_velocity_total
);

    function automatic logic [XW-1:0] abs64(input logic signed [XW-1:0] v);
        return v[XW-1] ? XW'(-v) : XW'(v);
    endfunction

    function automatic logic [YW-1:0] abs34(input logic signed [EW-1:0] v);
        logic [EW-1:0] m;
        m = v[EW-1] ? EW'(-v) : EW'(v);
        return m[YW-1:0];
    endfunction

    // configuration registers
    logic [PW-1:0] py_reg, pv_reg, pm_reg, pa_reg, k_reg, ka_reg;
    logic [HW-1:0] h_reg;

    // sample latch
    logic [JW-1:0]        j_reg;
    logic signed [DW-1:0] y_reg, v_reg, g_reg;

    // joint stores
    logic signed [DW-1:0]  mu_st [NUM_JOINTS];
    logic signed [DW-1:0]  mp_st [NUM_JOINTS];
    logic signed [DW-1:0]  ma_st [NUM_JOINTS];
    logic signed [DW-1:0]  tq_st [NUM_JOINTS];
    logic [NUM_JOINTS-1:0] started_reg;

    // working values
    logic signed [DW-1:0] mu_reg, mp_reg, ma_reg, tq_reg;
    logic signed [EW-1:0] ey_reg, ev_reg, em_reg, ea_reg;
    logic [XW-1:0]        t_reg;
    logic signed [XW-1:0] wy_reg, wv_reg, wm_reg, wa_reg;
    logic signed [XW-1:0] d1_reg, d2_reg, d3_reg, g1_reg;
    logic [AW-1:0]        en_acc_reg, pos_acc_reg, vel_acc_reg;

    // multiplier
    logic [XW-1:0]  xm_reg;
    logic [YW-1:0]  yo_reg;
    logic           neg_reg;
    mmode_t         mode_reg;
    logic [PRW-1:0] prod_reg;

    // result register
    logic result_valid_reg;
    logic last;

    assign last          = (j_reg == JW'(NUM_JOINTS - 1));
    assign stat.joint_ok = (j_reg < JW'(NUM_JOINTS));
    assign stat.out_free = !result_valid_reg || result_ready;
    assign result_valid  = result_valid_reg;

    // config writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            py_reg <= RST_PY;
            pv_reg <= RST_PV;
            pm_reg <= RST_PM;
            pa_reg <= RST_PA;
            k_reg  <= RST_K;
            ka_reg <= RST_KA;
            h_reg  <= RST_H;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                REG_PY:  py_reg <= cfg_data[PW-1:0];
                REG_PV:  pv_reg <= cfg_data[PW-1:0];
                REG_PM:  pm_reg <= cfg_data[PW-1:0];
                REG_PA:  pa_reg <= cfg_data[PW-1:0];
                REG_K:   k_reg  <= cfg_data[PW-1:0];
                REG_KA:  ka_reg <= cfg_data[PW-1:0];
                REG_H:   h_reg  <= cfg_data[HW-1:0];
                default: ;
            endcase
        end
    end

    // sample latch
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            j_reg <= joint_index;
            y_reg <= measured_position;
            v_reg <= measured_velocity;
            g_reg <= goal_position;
        end
    end

    // operand select for the current micro op
    logic signed [XW-1:0] sx;
    logic                 use_t;
    logic [YW-1:0]        opb;
    mmode_t               mode;

    always_comb
    begin
        sx    = '0;
        use_t = 1'b0;
        opb   = '0;
        mode  = M_S20;
        case (cmd.uop)
            U_SQY_A: begin sx = XW'(ey_reg); opb = YW'(py_reg); mode = M_RAW; end
            U_SQY_B: begin use_t = 1'b1; opb = abs34(ey_reg); mode = M_W40; end
            U_SQV_A: begin sx = XW'(ev_reg); opb = YW'(pv_reg); mode = M_RAW; end
            U_SQV_B: begin use_t = 1'b1; opb = abs34(ev_reg); mode = M_W40; end
            U_SQM_A: begin sx = XW'(em_reg); opb = YW'(pm_reg); mode = M_RAW; end
            U_SQM_B: begin use_t = 1'b1; opb = abs34(em_reg); mode = M_W40; end
            U_SQA_A: begin sx = XW'(ea_reg); opb = YW'(pa_reg); mode = M_RAW; end
            U_SQA_B: begin use_t = 1'b1; opb = abs34(ea_reg); mode = M_W40; end
            U_WY:    begin sx = XW'(ey_reg); opb = YW'(py_reg); end
            U_WV:    begin sx = XW'(ev_reg); opb = YW'(pv_reg); end
            U_WM:    begin sx = XW'(em_reg); opb = YW'(pm_reg); end
            U_WA:    begin sx = XW'(ea_reg); opb = YW'(pa_reg); end
            U_D1:    begin sx = wm_reg - wy_reg; opb = YW'(k_reg); end
            U_D2:    begin sx = wm_reg + wa_reg - wv_reg; opb = YW'(k_reg); end
            U_D3:    begin sx = wa_reg; opb = YW'(k_reg); end
            U_MU:    begin sx = d1_reg; opb = YW'(h_reg); mode = M_S32; end
            U_MP:    begin sx = d2_reg; opb = YW'(h_reg); mode = M_S32; end
            U_MA:    begin sx = d3_reg; opb = YW'(h_reg); mode = M_S32; end
            U_GV:    begin sx = XW'(v_reg) - XW'(mp_reg); opb = YW'(pv_reg); end
            U_GY:    begin sx = XW'(y_reg) - XW'(mu_reg); opb = YW'(py_reg); end
            U_GKA:   begin sx = g1_reg; opb = YW'(ka_reg); end
            U_TQ:    begin sx = g1_reg; opb = YW'(h_reg); mode = M_S32; end
            default: ;
        endcase
    end

    // multiplier: operand latch, low half, high half
    logic [64:0] lo_p, hi_p;
    assign lo_p = 65'(xm_reg[31:0]) * 65'(yo_reg);
    assign hi_p = 65'(xm_reg[63:32]) * 65'(yo_reg);

    always_ff @(posedge clk)
    begin
        if (cmd.setup)
        begin
            xm_reg   <= use_t ? t_reg : abs64(sx);
            neg_reg  <= !use_t && sx[XW-1];
            yo_reg   <= opb;
            mode_reg <= mode;
        end
        if (cmd.mlo)
            prod_reg <= PRW'(lo_p);
        else if (cmd.mhi)
            prod_reg <= prod_reg + {hi_p, 32'b0};
    end

    // product scaling: floor shift, saturation, sign
    logic [PRW-1:0]       q, q1;
    logic                 rnz;
    logic [59:0]          qmag;
    logic signed [XW-1:0] sres;
    logic [AW-1:0]        wsq;

    always_comb
    begin
        if (mode_reg == M_S32)
        begin
            q   = prod_reg >> 32;
            rnz = |prod_reg[31:0];
        end
        else
        begin
            q   = prod_reg >> 20;
            rnz = |prod_reg[19:0];
        end
        q1   = q + PRW'(neg_reg && rnz);
        qmag = (|q1[PRW-1:60]) ? SAT_MID : q1[59:0];
        sres = neg_reg ? -$signed({4'b0, qmag}) : $signed({4'b0, qmag});
        wsq  = (|prod_reg[PRW-1:80]) ? MAX40 : prod_reg[79:40];
    end

    // working values: load, differences, post results
    always_ff @(posedge clk)
    begin
        if (cmd.read)
        begin
            mu_reg <= started_reg[j_reg] ? mu_st[j_reg] : y_reg;
            mp_reg <= started_reg[j_reg] ? mp_st[j_reg] : v_reg;
            ma_reg <= ma_st[j_reg];
            tq_reg <= tq_st[j_reg];
        end
        if (cmd.diff)
        begin
            ey_reg <= EW'(y_reg) - EW'(mu_reg);
            ev_reg <= EW'(v_reg) - EW'(mp_reg);
            em_reg <= EW'(mp_reg) + EW'(mu_reg) - EW'(g_reg);
            ea_reg <= EW'(ma_reg) + EW'(mp_reg);
        end
        if (cmd.post)
        begin
            case (cmd.uop)
                U_SQY_A, U_SQV_A, U_SQM_A, U_SQA_A: t_reg <= prod_reg[XW-1:0];
                U_WY:  wy_reg <= sres;
                U_WV:  wv_reg <= sres;
                U_WM:  wm_reg <= sres;
                U_WA:  wa_reg <= sres;
                U_D1:  d1_reg <= XW'(mp_reg) - sres;
                U_D2:  d2_reg <= XW'(ma_reg) - sres;
                U_D3:  d3_reg <= -sres;
                U_MU:  mu_reg <= sat32(XW'(mu_reg) + sres);
                U_MP:  mp_reg <= sat32(XW'(mp_reg) + sres);
                U_MA:  ma_reg <= sat32(XW'(ma_reg) + sres);
                U_GV:  g1_reg <= sres;
                U_GY:  g1_reg <= g1_reg + sres;
                U_GKA: g1_reg <= sres;
                U_TQ:  tq_reg <= sat32(XW'(tq_reg) - sres);
                default: ;
            endcase
        end
    end

    // weighted squared error accumulators
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            en_acc_reg  <= '0;
            pos_acc_reg <= '0;
            vel_acc_reg <= '0;
        end
        else if (cmd.post)
        begin
            case (cmd.uop)
                U_SQY_B:
                begin
                    pos_acc_reg <= add40(pos_acc_reg, wsq);
                    en_acc_reg  <= add40(en_acc_reg, wsq);
                end
                U_SQV_B:
                begin
                    vel_acc_reg <= add40(vel_acc_reg, wsq);
                    en_acc_reg  <= add40(en_acc_reg, wsq);
                end
                U_SQM_B, U_SQA_B: en_acc_reg <= add40(en_acc_reg, wsq);
                default: ;
            endcase
        end
        else if (cmd.commit && last)
        begin
            en_acc_reg  <= '0;
            pos_acc_reg <= '0;
            vel_acc_reg <= '0;
        end
    end

    // joint stores with reset state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            started_reg <= '0;
            for (int i = 0; i < NUM_JOINTS; i++)
            begin
                ma_st[i] <= '0;
                tq_st[i] <= '0;
            end
        end
        else if (cmd.commit)
        begin
            started_reg[j_reg] <= 1'b1;
            ma_st[j_reg]       <= ma_reg;
            tq_st[j_reg]       <= tq_reg;
        end
    end

    // belief stores, written on every commit
    always_ff @(posedge clk)
    begin
        if (cmd.commit)
        begin
            mu_st[j_reg] <= mu_reg;
            mp_st[j_reg] <= mp_reg;
        end
    end

    // result word
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            result_valid_reg <= 1'b0;
        else if (cmd.commit)
            result_valid_reg <= 1'b1;
        else if (result_ready)
            result_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.commit)
        begin
            joint_out            <= j_reg;
            torque               <= tq_reg;
            belief_position      <= mu_reg;
            belief_velocity      <= mp_reg;
            belief_acceleration  <= ma_reg;
            step_done            <= last;
            free_energy          <= last ? en_acc_reg : '0;
            error_position_total <= last ? pos_acc_reg : '0;
            error_velocity_total <= last ? vel_acc_reg : '0;
        end
    end

endmodule

// ===== rtl/active_inference_joint_controller_core.sv =====
// ----------------------------------------------------------------------------
// active_inference_joint_controller_core
// Per-joint belief and torque update with error totals over a control step.
//
//   channel  dir  handshake     word
//   sample   in   valid/ready   joint index, position, velocity, goal
//   result   out  valid/ready   joint, torque, beliefs, step totals
//   cfg      in   valid/ready   register index, write data
//
// A sample runs 22 multiplies through one shared 64x33 multiplier, each
// through operand latch, low half, high half and scale, plus load, error and
// commit steps. An out-of-range joint index is dropped without a result.
// Reset is asynchronous, active low; config registers return to defaults.
// A new sample is taken while an earlier result still waits; a commit waits
// for the result register to drain. Config writes are always accepted.
// ----------------------------------------------------------------------------
module active_inference_joint_controller_core import aijc_pkg::*;
(
    input logic           clk,
    input logic           rst_n,
    aijc_sample_if.sink   sample,
    aijc_result_if.source result,
    aijc_cfg_if.sink      cfg
);

    cmd_t  cmd;
    stat_t stat;

    assign cfg.ready = 1'b1;

    // sequencer
    aijc_ctrl u_ctrl
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .sample_valid (sample.valid),
        .sample_ready (sample.ready),
        .stat         (stat),
        .cmd          (cmd)
    );

    // arithmetic and storage
    aijc_datapath u_datapath
    (
        .clk                  (clk),
        .rst_n                (rst_n),
        .cmd                  (cmd),
        .stat                 (stat),
        .joint_index          (sample.joint_index),
        .measured_position    (sample.measured_position),
        .measured_velocity    (sample.measured_velocity),
        .goal_position        (sample.goal_position),
        .cfg_write            (cfg.valid),
        .cfg_index            (cfg.index),
        .cfg_data             (cfg.data),
        .result_ready         (result.ready),
        .result_valid         (result.valid),
        .joint_out            (result.joint_out),
        .torque               (result.torque),
        .belief_position      (result.belief_position),
        .belief_velocity      (result.belief_velocity),
        .belief_acceleration  (result.belief_acceleration),
        .step_done            (result.step_done),
        .free_energy          (result.free_energy),
        .error_position_total (result.error_position_total),
        .error_velocity_total (result.error_velocity_total)
    );

endmodule

// ===== rtl/aijc_checker.sv =====
// ----------------------------------------------------------------------------
// aijc_checker
// Port-level checks of the joint controller, bound to the top level.
// ----------------------------------------------------------------------------
module aijc_checker import aijc_pkg::*;
(
    input logic          clk,
    input logic          rst_n,
    input logic          sample_valid,
    input logic          sample_ready,
    input logic          result_valid,
    input logic          result_ready,
    input logic [JW-1:0] joint_out,
    input logic          step_done,
    input logic [AW-1:0] free_energy,
    input logic [AW-1:0] error_position_total,
    input logic [AW-1:0] error_velocity_total
);

    // a result word holds until taken
    a_result_hold: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result_ready |=> result_valid)
        else $error("result word dropped while stalled");

    // one sample at a time
    a_one_sample: assert property (@(posedge clk) disable iff (!rst_n)
        sample_valid && sample_ready |=> !sample_ready)
        else $error("sample taken while busy");

    // step done exactly on the last joint
    a_step_last: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> (step_done == (joint_out == JW'(NUM_JOINTS - 1))))
        else $error("step_done mismatch");

    // totals are zero outside the last joint
    a_totals_zero: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !step_done |->
            (free_energy == '0 && error_position_total == '0 &&
             error_velocity_total == '0))
        else $error("totals not zero");

    // energy covers the position and velocity terms
    a_energy_bound: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && step_done |->
            (free_energy >= error_position_total && free_energy >= error_velocity_total))
        else $error("energy below error total");

endmodule

bind active_inference_joint_controller_core aijc_checker u_aijc_checker
(
    .clk                  (clk),
    .rst_n                (rst_n),
    .sample_valid         (sample.valid),
    .sample_ready         (sample.ready),
    .result_valid         (result.valid),
    .result_ready         (result.ready),
    .joint_out            (result.joint_out),
    .step_done            (result.step_done),
    .free_energy          (result.free_energy),
    .error_position_total (result.error_position_total),
    .error_velocity_total (result.error_velocity_total)
);

// ===== tb/testbench.sv =====
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the joint controller core. Samples are driven
// through the sample channel and each one with an in-range joint index is
// predicted by a local model of the belief, torque and free energy update.
// Every result word is checked in order against that prediction. Register
// settings are changed between phases and include the all-zero and all-ones
// extremes. Random idling on both channels shifts the handshake timing.
// ----------------------------------------------------------------------------
module testbench;
    import aijc_pkg::*;

    typedef logic signed [127:0] wide_t;

    typedef struct {
        logic [JW-1:0]        joint;
        logic signed [DW-1:0] torque;
        logic signed [DW-1:0] pos;
        logic signed [DW-1:0] vel;
        logic signed [DW-1:0] acc;
        logic                 done;
        logic [AW-1:0]        energy;
        logic [AW-1:0]        pos_err;
        logic [AW-1:0]        vel_err;
    } joint_update_t;

    logic clk;
    logic rst_n;

    aijc_sample_if sample ();
    aijc_result_if result ();
    aijc_cfg_if    cfg ();

    active_inference_joint_controller_core dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .sample (sample),
        .result (result),
        .cfg    (cfg)
    );

    // local copy of the controller state
    logic [31:0]          ctl_regs [7];
    logic signed [DW-1:0] pos_belief [NUM_JOINTS];
    logic signed [DW-1:0] vel_belief [NUM_JOINTS];
    logic signed [DW-1:0] acc_belief [NUM_JOINTS];
    logic signed [DW-1:0] torque_cmd [NUM_JOINTS];
    logic                 started [NUM_JOINTS];
    logic [AW-1:0]        energy_sum;
    logic [AW-1:0]        pos_err_sum;
    logic [AW-1:0]        vel_err_sum;

    joint_update_t pending_updates [$];

    int snd_idle_pct;
    int rcv_idle_pct;
    int mismatches;
    int samples_sent;
    int updates_checked;
    int steps_closed;

    // clock
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // run limit
    initial
    begin
        #20000000;
        $display("testbench: errors");
        $finish;
    end

    // floor(a*b / 2^s), clamped to +-(2^60-1)
    function automatic logic signed [63:0] scaled_mul(input logic signed [63:0] a,
                                                      input logic [31:0] b, input int s);
        wide_t p;
        wide_t q;
        wide_t lim;
        lim = (wide_t'(1) <<< 60) - 1;
        p = wide_t'(a) * $signed({96'd0, b});
        q = p >>> s;
        if (q > lim)
            q = lim;
        else if (q < -lim)
            q = -lim;
        return q[63:0];
    endfunction

    // floor(p*e*e / 2^40), clamped to 40 bits
    function automatic logic [AW-1:0] weighted_sq(input logic signed [63:0] e,
                                                  input logic [31:0] p);
        logic [127:0] m;
        logic [127:0] r;
        m = e[63] ? -{{64{e[63]}}, e} : {64'd0, e};
        r = (m * m * {96'd0, p}) >> 40;
        return (r > {88'd0, MAX40}) ? MAX40 : r[AW-1:0];
    endfunction

    function automatic logic signed [DW-1:0] clamp32(input logic signed [63:0] v);
        if (v > 64'sd2147483647)
            return 32'sh7fffffff;
        if (v < -64'sd2147483648)
            return 32'sh80000000;
        return v[DW-1:0];
    endfunction

    function automatic logic [AW-1:0] sum40(input logic [AW-1:0] a, input logic [AW-1:0] b);
        logic [AW:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[AW] ? MAX40 : s[AW-1:0];
    endfunction

    // one gradient step of a joint; returns the expected result word
    function automatic joint_update_t update_joint(input logic [JW-1:0] j,
            input logic signed [DW-1:0] y, input logic signed [DW-1:0] v,
            input logic signed [DW-1:0] g);
        joint_update_t u;
        logic [31:0] py, pv, pm, pa, k, ka, h;
        logic signed [DW-1:0] mu, mp, ma;
        logic signed [63:0] ey, ev, em, ea, wy, wv, wm, wa, d1, d2, d3, gt;
        logic [AW-1:0] ty, tv, tm, ta;
        py = ctl_regs[REG_PY];
        pv = ctl_regs[REG_PV];
        pm = ctl_regs[REG_PM];
        pa = ctl_regs[REG_PA];
        k  = ctl_regs[REG_K];
        ka = ctl_regs[REG_KA];
        h  = ctl_regs[REG_H];
        if (!started[j])
        begin
            started[j] = 1'b1;
            pos_belief[j] = y;
            vel_belief[j] = v;
        end
        mu = pos_belief[j];
        mp = vel_belief[j];
        ma = acc_belief[j];
        ey = 64'(y) - 64'(mu);
        ev = 64'(v) - 64'(mp);
        em = 64'(mp) + 64'(mu) - 64'(g);
        ea = 64'(ma) + 64'(mp);

        // energy terms use the old beliefs
        ty = weighted_sq(ey, py);
        tv = weighted_sq(ev, pv);
        tm = weighted_sq(em, pm);
        ta = weighted_sq(ea, pa);
        pos_err_sum = sum40(pos_err_sum, ty);
        vel_err_sum = sum40(vel_err_sum, tv);
        energy_sum = sum40(energy_sum, sum40(sum40(ty, tv), sum40(tm, ta)));

        // belief descent
        wy = scaled_mul(ey, py, 20);
        wv = scaled_mul(ev, pv, 20);
        wm = scaled_mul(em, pm, 20);
        wa = scaled_mul(ea, pa, 20);
        d1 = 64'(mp) - scaled_mul(wm - wy, k, 20);
        d2 = 64'(ma) - scaled_mul(wm + wa - wv, k, 20);
        d3 = -scaled_mul(wa, k, 20);
        mu = clamp32(64'(mu) + scaled_mul(d1, h, 32));
        mp = clamp32(64'(mp) + scaled_mul(d2, h, 32));
        ma = clamp32(64'(ma) + scaled_mul(d3, h, 32));
        pos_belief[j] = mu;
        vel_belief[j] = mp;
        acc_belief[j] = ma;

        // torque from the new beliefs
        gt = scaled_mul(64'(v) - 64'(mp), pv, 20) + scaled_mul(64'(y) - 64'(mu), py, 20);
        torque_cmd[j] = clamp32(64'(torque_cmd[j])
                                - scaled_mul(scaled_mul(gt, ka, 20), h, 32));

        u.joint  = j;
        u.torque = torque_cmd[j];
        u.pos    = mu;
        u.vel    = mp;
        u.acc    = ma;
        u.done   = (j == JW'(NUM_JOINTS - 1));
        u.energy  = '0;
        u.pos_err = '0;
        u.vel_err = '0;
        if (u.done)
        begin
            u.energy  = energy_sum;
            u.pos_err = pos_err_sum;
            u.vel_err = vel_err_sum;
            energy_sum  = '0;
            pos_err_sum = '0;
            vel_err_sum = '0;
        end
        return u;
    endfunction

    // one field compare
    task automatic check_field(input string name, input logic [63:0] want,
                               input logic [63:0] got);
        if (got !== want)
        begin
            mismatches++;
            if (mismatches <= 10)
                $display("mismatch %s: expected %h actual %h", name, want, got);
        end
    endtask

    // result checker and receiver stalls
    always @(posedge clk)
    begin
        joint_update_t u;
        if (rst_n && result.valid && result.ready)
        begin
            if (pending_updates.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("mismatch: result word with nothing expected, joint %0d",
                             result.joint_out);
            end
            else
            begin
                u = pending_updates.pop_front();
                check_field("joint", 64'(u.joint), 64'(result.joint_out));
                check_field("torque", 64'(u.torque), 64'(result.torque));
                check_field("belief_position", 64'(u.pos), 64'(result.belief_position));
                check_field("belief_velocity", 64'(u.vel), 64'(result.belief_velocity));
                check_field("belief_acceleration", 64'(u.acc),
                            64'(result.belief_acceleration));
                check_field("step_done", 64'(u.done), 64'(result.step_done));
                check_field("free_energy", 64'(u.energy), 64'(result.free_energy));
                check_field("error_position_total", 64'(u.pos_err),
                            64'(result.error_position_total));
                check_field("error_velocity_total", 64'(u.vel_err),
                            64'(result.error_velocity_total));
                updates_checked++;
                if (u.done)
                    steps_closed++;
            end
        end
        result.ready <= ($urandom_range(99) >= rcv_idle_pct);
    end

    // send one sample word and predict its result if the joint index is in range
    task automatic send_sample(input logic [JW-1:0] j, input logic signed [DW-1:0] y,
                               input logic signed [DW-1:0] v, input logic signed [DW-1:0] g);
        if ($urandom_range(99) < snd_idle_pct)
        begin
            sample.valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clk);
        end
        sample.valid             <= 1'b1;
        sample.joint_index       <= j;
        sample.measured_position <= y;
        sample.measured_velocity <= v;
        sample.goal_position     <= g;
        @(posedge clk);
        while (!sample.ready)
            @(posedge clk);
        if (j < NUM_JOINTS)
        begin
            pending_updates.push_back(update_joint(j, y, v, g));
            samples_sent++;
        end
    endtask

    // stop sending and let every expected word drain
    task automatic drain_results();
        sample.valid <= 1'b0;
        @(posedge clk);
        while (pending_updates.size() != 0)
            @(posedge clk);
        repeat (120) @(posedge clk);
    endtask

    task automatic write_reg(input reg_idx_t idx, input logic [31:0] value);
        cfg.valid <= 1'b1;
        cfg.index <= idx;
        cfg.data  <= value;
        @(posedge clk);
        while (!cfg.ready)
            @(posedge clk);
        cfg.valid <= 1'b0;
        ctl_regs[idx] = (idx == REG_H) ? value : {1'b0, value[30:0]};
    endtask

    task automatic write_all_regs(input logic [31:0] py, input logic [31:0] pv,
            input logic [31:0] pm, input logic [31:0] pa, input logic [31:0] k,
            input logic [31:0] ka, input logic [31:0] h);
        drain_results();
        write_reg(REG_PY, py);
        write_reg(REG_PV, pv);
        write_reg(REG_PM, pm);
        write_reg(REG_PA, pa);
        write_reg(REG_K, k);
        write_reg(REG_KA, ka);
        write_reg(REG_H, h);
        @(posedge clk);
    endtask

    function automatic logic signed [DW-1:0] pick_value();
        logic [31:0] r;
        case ($urandom_range(9))
            0, 1, 2, 3, 4: r = $urandom_range(0, 8388608) - 32'd4194304;
            5, 6, 7:       r = $urandom;
            default:
            begin
                case ($urandom_range(4))
                    0: r = 32'h7fffffff;
                    1: r = 32'h80000000;
                    2: r = 32'h00000001;
                    3: r = 32'hffffffff;
                    default: r = 32'h0;
                endcase
            end
        endcase
        return r;
    endfunction

    // directed words: extremes, ignored index, repeated and last joint
    task automatic test_directed();
        send_sample(3'd0, 32'sh7fffffff, 32'sh80000000, 32'sh0);
        send_sample(3'd1, 32'sh80000000, 32'sh7fffffff, 32'sh7fffffff);
        send_sample(3'd2, 32'sh0, 32'sh0, 32'sh80000000);
        send_sample(3'd3, 32'sh00100000, -32'sh00100000, 32'sh00200000);
        send_sample(3'd7, 32'sh12345678, 32'sh0, 32'sh0);
        send_sample(3'd3, 32'sh00110000, -32'sh000f0000, 32'sh00200000);
        send_sample(3'd4, -32'sh1, 32'sh1, 32'sh0);
        send_sample(3'd5, 32'sh55555555, 32'shaaaaaaaa, 32'sh55555555);
        send_sample(3'd6, 32'shaaaaaaaa, 32'sh55555555, 32'shaaaaaaaa);
        send_sample(3'd0, 32'sh80000000, 32'sh7fffffff, 32'sh7fffffff);
        send_sample(3'd1, 32'sh7fffffff, 32'sh80000000, 32'sh80000000);
        send_sample(3'd6, 32'sh0, 32'sh0, 32'sh0);
        send_sample(3'd6, 32'sh7fffffff, 32'sh7fffffff, 32'sh80000000);
        send_sample(3'd7, 32'sh0, 32'sh0, 32'sh0);
        send_sample(3'd2, 32'sh00080000, 32'sh0, 32'sh00080000);
        send_sample(3'd5, -32'sh00400000, 32'sh00020000, 32'sh0);
        send_sample(3'd6, 32'sh00010000, -32'sh00010000, 32'sh00300000);
    endtask

    // control steps over all joints with random content and some broken steps
    task automatic test_random(input int count);
        int sent;
        sent = 0;
        while (sent < count)
        begin
            for (int j = 0; j < NUM_JOINTS; j++)
            begin
                if ($urandom_range(99) < 3)
                    send_sample(3'd7, pick_value(), pick_value(), pick_value());
                if ($urandom_range(99) < 5)
                    continue;
                send_sample(JW'(j), pick_value(), pick_value(), pick_value());
                sent++;
                if ($urandom_range(99) < 5)
                begin
                    send_sample(JW'(j), pick_value(), pick_value(), pick_value());
                    sent++;
                end
            end
        end
    endtask

    initial
    begin
        rst_n = 1'b0;
        sample.valid = 1'b0;
        sample.joint_index = '0;
        sample.measured_position = '0;
        sample.measured_velocity = '0;
        sample.goal_position = '0;
        result.ready = 1'b0;
        cfg.valid = 1'b0;
        cfg.index = REG_PY;
        cfg.data = '0;
        mismatches = 0;
        samples_sent = 0;
        updates_checked = 0;
        steps_closed = 0;
        energy_sum = '0;
        pos_err_sum = '0;
        vel_err_sum = '0;
        ctl_regs[REG_PY] = 32'(RST_PY);
        ctl_regs[REG_PV] = 32'(RST_PV);
        ctl_regs[REG_PM] = 32'(RST_PM);
        ctl_regs[REG_PA] = 32'(RST_PA);
        ctl_regs[REG_K]  = 32'(RST_K);
        ctl_regs[REG_KA] = 32'(RST_KA);
        ctl_regs[REG_H]  = RST_H;
        for (int i = 0; i < NUM_JOINTS; i++)
        begin
            pos_belief[i] = '0;
            vel_belief[i] = '0;
            acc_belief[i] = '0;
            torque_cmd[i] = '0;
            started[i] = 1'b0;
        end
        snd_idle_pct = 32;
        rcv_idle_pct = 57;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // sender idles 32, receiver 57
        test_directed();
        test_random(330);
        write_all_regs(32'h7fffffff, 32'h7fffffff, 32'h7fffffff, 32'h7fffffff,
                       32'h7fffffff, 32'h7fffffff, 32'hffffffff);
        test_random(120);

        // swapped idling
        snd_idle_pct = 57;
        rcv_idle_pct = 32;
        write_all_regs(32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0);
        test_random(100);
        write_all_regs($urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
        test_random(100);
        write_all_regs($urandom_range(0, 1 << 22), $urandom_range(0, 1 << 22),
                       $urandom_range(0, 1 << 21), $urandom_range(0, 1 << 21),
                       $urandom_range(0, 1 << 25), $urandom_range(0, 1 << 30),
                       $urandom_range(0, 1 << 26));
        test_random(150);

        // no idling, back to defaults
        snd_idle_pct = 0;
        rcv_idle_pct = 0;
        write_all_regs(32'(RST_PY), 32'(RST_PV), 32'(RST_PM), 32'(RST_PA),
                       32'(RST_K), 32'(RST_KA), RST_H);
        test_random(250);
        drain_results();

        $display("run covered %0d samples, %0d result words, %0d closed control steps",
                 samples_sent, updates_checked, steps_closed);
        $display("register sets: defaults, all ones, all zeros, random; %0d mismatches",
                 mismatches);
        if (mismatches == 0)
            $display("testbench: clean");
        else
            $display("testbench: errors");
        $finish;
    end

endmodule
